>>> rtl/hcbp_pkg.sv
// Shared types, constants and helpers for the Huffman code bit packer.
// No dependencies; imported by every module of the block.
package hcbp_pkg;

  localparam int SYMBOLS      = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYM_W        = (SYMBOLS > 2) ? $clog2(SYMBOLS) : 1;
  localparam int LEN_LIM      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int ACC_W        = 40;  // up to 7 pending bits plus a 32-bit code

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ENC  = 2'd1;
  localparam logic [1:0] REQ_FIN  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  symbol;
    logic [5:0]  code_len;
    logic [31:0] code_bits;
  } hcbp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } hcbp_out_t;

  typedef struct packed {
    logic [5:0]  len;
    logic [31:0] word;
  } hcbp_code_t;

  // Request held between code store read and packer.
  typedef struct packed {
    logic vld;
    logic fin;
  } hcbp_job_t;

  function automatic logic [5:0] clamp_len(input logic [5:0] len);
    logic [5:0] lim;
    lim = 6'(LEN_LIM);
    return (len > lim) ? lim : len;
  endfunction

endpackage

>>> rtl/hcbp_code_store.sv
// Code store: one synchronous memory of code lengths and words, registered read.
// Per-entry valid bits give zero length for entries never loaded. Uses hcbp_pkg.
module hcbp_code_store
  import hcbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] addr,
  input  hcbp_code_t       wr_code,
  output hcbp_code_t       rd_code
);

  hcbp_code_t         mem [SYMBOLS];
  hcbp_code_t         q_r;
  logic [SYMBOLS-1:0] vld_r;
  logic               hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_code;
    end
    if (rd_en) begin
      q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= vld_r[addr];
      end
    end
  end

  assign rd_code.len  = hit_r ? q_r.len : 6'd0;
  assign rd_code.word = q_r.word;

endmodule

>>> rtl/hcbp_packer.sv
// Bit packer: MSB-aligned accumulator, byte emission and flush sequencing,
// with the output register. Uses hcbp_pkg.
module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hcbp_job_t  job,
  input  hcbp_code_t code,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output hcbp_out_t  out_data
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             fin_r, fin_nxt;
  logic [2:0]       fin_cnt_r, fin_cnt_nxt;
  logic             ov_r, ov_nxt;
  hcbp_out_t        od_r, od_nxt;

  logic             idle;
  logic             can_emit;
  logic [5:0]       sh;
  logic [31:0]      aligned;
  logic [ACC_W-1:0] spread;

  assign idle     = !fin_r && (cnt_r < 6'd8);
  assign take     = job.vld && idle;
  assign can_emit = !ov_r || out_ready;

  // Left-align the code word, then slot it behind the pending bits.
  assign sh      = 6'd32 - code.len;
  assign aligned = code.word << sh;
  assign spread  = {aligned, 8'b0} >> cnt_r[2:0];

  always_comb begin
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    fin_nxt     = fin_r;
    fin_cnt_nxt = fin_cnt_r;
    ov_nxt      = ov_r && !out_ready;
    od_nxt      = od_r;
    if (take) begin
      if (job.fin) begin
        fin_nxt     = 1'b1;
        fin_cnt_nxt = cnt_r[2:0];
      end else begin
        acc_nxt = acc_r | spread;
        cnt_nxt = cnt_r + code.len;
      end
    end else if (can_emit && fin_r) begin
      ov_nxt = 1'b1;
      if (cnt_r != 6'd0) begin
        // partial byte, already zero padded on the right
        od_nxt  = '{out_byte: acc_r[ACC_W-1 -: 8], last: 1'b0};
        acc_nxt = '0;
        cnt_nxt = 6'd0;
      end else begin
        od_nxt  = '{out_byte: {5'b0, fin_cnt_r}, last: 1'b1};
        fin_nxt = 1'b0;
      end
    end else if (can_emit && (cnt_r >= 6'd8)) begin
      ov_nxt  = 1'b1;
      od_nxt  = '{out_byte: acc_r[ACC_W-1 -: 8], last: 1'b0};
      acc_nxt = acc_r << 8;
      cnt_nxt = cnt_r - 6'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= 6'd0;
      fin_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_cnt_r <= fin_cnt_nxt;
    od_r      <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'(ACC_W - 1))
    else $error("packer bit count out of range");

  a_fin_partial: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (cnt_r < 6'd8))
    else $error("flush with a full byte still pending");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && od_r.last) |-> (od_r.out_byte < 8'd8))
    else $error("count byte above seven");

  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !job.fin) |=> (cnt_r == $past(cnt_r) + $past(code.len)))
    else $error("bit count not advanced by code length");
`endif

endmodule

>>> rtl/huffman_code_bit_packer.sv
// Huffman code bit packer: code store plus byte packer.
// Path: code store read, stage 1, packer accumulator, then the output register.
// Throughput: the packer takes one item per cycle when free; an encode then holds
//   it while each completed byte is emitted, a finish until its count byte is out.
// Reset (sync, active low): code lengths read as zero via valid bits, pending bits
//   cleared; code words stay undefined until loaded. No clearing pass.
module huffman_code_bit_packer
  import hcbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hcbp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hcbp_out_t out_data
);

  logic       in_acc;
  logic       sym_ok;
  logic       is_fin;
  logic       wr_en;
  logic       rd_en;
  hcbp_code_t wr_code;
  hcbp_code_t rd_code;
  logic       take;

  // Stage 1: request waiting for the packer, code read data alongside.
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_fin_r, s1_fin_nxt;
  hcbp_job_t  job;

  assign in_acc = in_valid && in_ready;
  assign sym_ok = {1'b0, in_data.symbol} < 9'(SYMBOLS);
  assign is_fin = (in_data.req_type == REQ_FIN);

  // Loads write at acceptance, encodes read at acceptance: store order
  // follows word order, so no forwarding is needed.
  assign wr_en   = in_acc && (in_data.req_type == REQ_LOAD) && sym_ok;
  assign rd_en   = in_acc && (in_data.req_type == REQ_ENC) && sym_ok;
  assign wr_code = '{len: clamp_len(in_data.code_len), word: in_data.code_bits};

  hcbp_code_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .rd_en   (rd_en),
    .addr    (in_data.symbol[SYM_W-1:0]),
    .wr_code (wr_code),
    .rd_code (rd_code)
  );

  // Stage 1 frees when the packer takes its job; read data holds meanwhile
  // since no new read is issued until the next word is accepted.
  assign in_ready = !s1_valid_r || take;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !take;
    s1_fin_nxt   = s1_fin_r;
    if (in_acc) begin
      s1_valid_nxt = rd_en || is_fin;
      s1_fin_nxt   = is_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_fin_r <= s1_fin_nxt;
  end

  assign job = '{vld: s1_valid_r, fin: s1_fin_r};

  hcbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .code      (rd_code),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
